@@ rtl/decimating_complex_fir_filter_defines.svh @@
// Assertion macros used by the checker file of the decimating complex FIR filter.
`ifndef DECIMATING_COMPLEX_FIR_FILTER_DEFINES_SVH
`define DECIMATING_COMPLEX_FIR_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define DCF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dcf assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define DCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dcf assertion failed");

`endif

@@ rtl/dcf_pkg.sv @@
// Package with the types, widths and codes of the decimating complex FIR filter.
`default_nettype none

package dcf_pkg;

   localparam int MAX_TAPS         = 64;
   localparam int SAMPLE_BITS      = 16;
   localparam int TAP_INDEX_BITS   = 6;
   localparam int CELL_IDX_BITS    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int PROD_BITS        = 2 * SAMPLE_BITS;
   localparam int SUM_BITS         = PROD_BITS + 1;
   localparam int OUT_BITS         = 39;
   localparam int NUM_TAPS_BITS    = 7;
   localparam int DECIMATION_BITS  = 5;
   localparam int PHASE_BITS       = 4;
   localparam int MAX_DECIMATION   = 16;
   localparam int NUM_TAPS_RESET   = 64;
   localparam int DECIMATION_RESET = 1;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 7;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_TAPS   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECIMATION = 2'd1;

   localparam logic ACTION_PUSH      = 1'b0;
   localparam logic ACTION_TAP_WRITE = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
   } cplx_type;

   typedef struct packed {
      logic                      shift;
      logic                      rotate;
      logic                      clear;
      logic                      tap_wr;
      logic [TAP_INDEX_BITS-1:0] tap_index;
      cplx_type                  tap;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/dcf_interfaces.sv @@
// Request, response and register-write channel interfaces of the FIR filter.
`default_nettype none

interface dcf_req_if import dcf_pkg::*; ();
   logic                             valid;
   logic                             ready;
   logic                             action;
   logic signed [SAMPLE_BITS-1:0]    sample_re;
   logic signed [SAMPLE_BITS-1:0]    sample_im;
   logic        [TAP_INDEX_BITS-1:0] tap_index;
   logic signed [SAMPLE_BITS-1:0]    tap_re;
   logic signed [SAMPLE_BITS-1:0]    tap_im;

   modport source (output valid, action, sample_re, sample_im, tap_index, tap_re, tap_im,
                   input ready);
   modport sink   (input valid, action, sample_re, sample_im, tap_index, tap_re, tap_im,
                   output ready);
endinterface

interface dcf_rsp_if import dcf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] out_re;
   logic signed [OUT_BITS-1:0] out_im;

   modport source (output valid, out_re, out_im, input ready);
   modport sink   (input valid, out_re, out_im, output ready);
endinterface

interface dcf_csr_if import dcf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/dcf_cell.sv @@
// One filter cell: holds one delayed sample and one tap, shifts or rotates with its neighbors.
`default_nettype none

module dcf_cell import dcf_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [CELL_IDX_BITS-1:0] cell_idx,
   input  wire cell_ctrl_type            ctrl,
   input  wire cplx_type                 shift_sample,
   input  wire cplx_type                 rot_sample,
   input  wire cplx_type                 rot_tap,
   output cplx_type                      sample,
   output cplx_type                      tap
);

   cplx_type sample_ff;
   cplx_type sample_in;
   cplx_type tap_ff;
   cplx_type tap_in;
   logic     idx_match;

   assign idx_match = (32'(ctrl.tap_index) == 32'(cell_idx));

   always_comb begin
      sample_in = sample_ff;
      tap_in    = tap_ff;
      if (ctrl.clear) begin
         sample_in = '0;
      end
      if (ctrl.shift) begin
         sample_in = shift_sample;
      end
      if (ctrl.rotate) begin
         sample_in = rot_sample;
         tap_in    = rot_tap;
      end
      if (ctrl.tap_wr && idx_match) begin
         tap_in = ctrl.tap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
         tap_ff    <= '0;
      end else begin
         sample_ff <= sample_in;
         tap_ff    <= tap_in;
      end
   end

   assign sample = sample_ff;
   assign tap    = tap_ff;

endmodule

`default_nettype wire

@@ rtl/dcf_cmac.sv @@
// Complex multiply-accumulate unit fed from the head cell of the chain.
`default_nettype none

module dcf_cmac import dcf_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  clear,
   input  wire logic                  prod_en,
   input  wire cplx_type              sample,
   input  wire cplx_type              tap,
   output logic signed [OUT_BITS-1:0] acc_re,
   output logic signed [OUT_BITS-1:0] acc_im
);

   logic signed [PROD_BITS-1:0] ac_ff;
   logic signed [PROD_BITS-1:0] bd_ff;
   logic signed [PROD_BITS-1:0] ad_ff;
   logic signed [PROD_BITS-1:0] bc_ff;
   logic signed [PROD_BITS-1:0] ac_in;
   logic signed [PROD_BITS-1:0] bd_in;
   logic signed [PROD_BITS-1:0] ad_in;
   logic signed [PROD_BITS-1:0] bc_in;
   logic                        prod_valid_ff;
   logic signed [SUM_BITS-1:0]  re_term;
   logic signed [SUM_BITS-1:0]  im_term;
   logic signed [OUT_BITS-1:0]  acc_re_ff;
   logic signed [OUT_BITS-1:0]  acc_im_ff;
   logic signed [OUT_BITS-1:0]  acc_re_in;
   logic signed [OUT_BITS-1:0]  acc_im_in;

   // The tap is (a + jb) and the sample is (c + jd).
   assign ac_in = tap.re * sample.re;
   assign bd_in = tap.im * sample.im;
   assign ad_in = tap.re * sample.im;
   assign bc_in = tap.im * sample.re;

   assign re_term = SUM_BITS'(ac_ff) - SUM_BITS'(bd_ff);
   assign im_term = SUM_BITS'(ad_ff) + SUM_BITS'(bc_ff);

   always_comb begin
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (clear) begin
         acc_re_in = '0;
         acc_im_in = '0;
      end else if (prod_valid_ff) begin
         acc_re_in = acc_re_ff + OUT_BITS'(re_term);
         acc_im_in = acc_im_ff + OUT_BITS'(im_term);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= prod_en;
      end
      ac_ff     <= ac_in;
      bd_ff     <= bd_in;
      ad_ff     <= ad_in;
      bc_ff     <= bc_in;
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
   end

   assign acc_re = acc_re_ff;
   assign acc_im = acc_im_ff;

endmodule

`default_nettype wire

@@ rtl/decimating_complex_fir_filter.sv @@
// Top level of the decimating complex FIR filter: cell chain, MAC, control and registers.
// A push request that does not complete a decimation period and a tap write are each done in
// the cycle in which they are taken. A push that completes the period makes the cell chain
// rotate once all the way round through the single complex multiply-accumulate unit at its
// head, one cell per cycle; the control then passes a drain state that accumulates the last
// product and a done state that loads the output register. Requests are refused during that
// time, and for longer if an earlier result is still waiting to be taken. The output register
// lets the next computation run while a result waits to be taken. A tap write clears the delay
// line and the decimation phase. Register writes are taken in every cycle.
`default_nettype none

module decimating_complex_fir_filter import dcf_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   dcf_req_if.sink    req_if,
   dcf_rsp_if.source  rsp_if,
   dcf_csr_if.sink    csr_if
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type                    state_ff;
   state_type                    state_in;
   logic [CELL_IDX_BITS-1:0]     cnt_ff;
   logic [CELL_IDX_BITS-1:0]     cnt_in;
   logic [PHASE_BITS-1:0]        phase_ff;
   logic [PHASE_BITS-1:0]        phase_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic signed [OUT_BITS-1:0]   out_re_ff;
   logic signed [OUT_BITS-1:0]   out_re_in;
   logic signed [OUT_BITS-1:0]   out_im_ff;
   logic signed [OUT_BITS-1:0]   out_im_in;
   logic [NUM_TAPS_BITS-1:0]     num_taps_ff;
   logic [DECIMATION_BITS-1:0]   decimation_ff;
   logic [NUM_TAPS_BITS-1:0]     taps_eff;
   logic [DECIMATION_BITS-1:0]   dec_eff;
   logic [DECIMATION_BITS-1:0]   phase_step;
   logic                         req_fire;
   logic                         csr_fire;
   logic                         start_mac;
   logic                         prod_en;
   logic signed [OUT_BITS-1:0]   acc_re;
   logic signed [OUT_BITS-1:0]   acc_im;
   cell_ctrl_type                cell_ctrl;
   cplx_type                     new_sample;
   cplx_type                     cell_sample [MAX_TAPS];
   cplx_type                     cell_tap [MAX_TAPS];

   assign req_fire = req_if.valid && (state_ff == ST_IDLE);
   assign csr_fire = csr_if.valid;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.out_re = out_re_ff;
   assign rsp_if.out_im = out_im_ff;

   always_comb begin
      if (num_taps_ff == '0) begin
         taps_eff = NUM_TAPS_BITS'(1);
      end else if (num_taps_ff > NUM_TAPS_BITS'(MAX_TAPS)) begin
         taps_eff = NUM_TAPS_BITS'(MAX_TAPS);
      end else begin
         taps_eff = num_taps_ff;
      end
      if (decimation_ff == '0) begin
         dec_eff = DECIMATION_BITS'(1);
      end else if (decimation_ff > DECIMATION_BITS'(MAX_DECIMATION)) begin
         dec_eff = DECIMATION_BITS'(MAX_DECIMATION);
      end else begin
         dec_eff = decimation_ff;
      end
   end

   assign phase_step = DECIMATION_BITS'(phase_ff) + DECIMATION_BITS'(1);

   assign new_sample.re = req_if.sample_re;
   assign new_sample.im = req_if.sample_im;

   assign cell_ctrl.shift     = req_fire && (req_if.action == ACTION_PUSH);
   assign cell_ctrl.rotate    = (state_ff == ST_ROTATE);
   assign cell_ctrl.clear     = req_fire && (req_if.action == ACTION_TAP_WRITE);
   assign cell_ctrl.tap_wr    = req_fire && (req_if.action == ACTION_TAP_WRITE);
   assign cell_ctrl.tap_index = req_if.tap_index;
   assign cell_ctrl.tap.re    = req_if.tap_re;
   assign cell_ctrl.tap.im    = req_if.tap_im;

   for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
      localparam int PREV = (i == 0) ? 0 : i - 1;
      localparam int NEXT = (i + 1) % MAX_TAPS;

      dcf_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cell_idx     (CELL_IDX_BITS'(i)),
         .ctrl         (cell_ctrl),
         .shift_sample ((i == 0) ? new_sample : cell_sample[PREV]),
         .rot_sample   (cell_sample[NEXT]),
         .rot_tap      (cell_tap[NEXT]),
         .sample       (cell_sample[i]),
         .tap          (cell_tap[i])
      );
   end

   assign prod_en = (state_ff == ST_ROTATE) && (NUM_TAPS_BITS'(cnt_ff) < taps_eff);

   dcf_cmac u_cmac (
      .clock   (clock),
      .reset   (reset),
      .clear   (start_mac),
      .prod_en (prod_en),
      .sample  (cell_sample[0]),
      .tap     (cell_tap[0]),
      .acc_re  (acc_re),
      .acc_im  (acc_im)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      out_re_in    = out_re_ff;
      out_im_in    = out_im_ff;
      start_mac    = 1'b0;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_if.action == ACTION_TAP_WRITE) begin
                  phase_in = '0;
               end else if (phase_step >= dec_eff) begin
                  phase_in  = '0;
                  cnt_in    = '0;
                  start_mac = 1'b1;
                  state_in  = ST_ROTATE;
               end else begin
                  phase_in = phase_step[PHASE_BITS-1:0];
               end
            end
         end
         ST_ROTATE: begin
            cnt_in = cnt_ff + CELL_IDX_BITS'(1);
            if (cnt_ff == CELL_IDX_BITS'(MAX_TAPS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               out_re_in    = acc_re;
               out_im_in    = acc_im;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      out_re_ff <= out_re_in;
      out_im_ff <= out_im_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_taps_ff   <= NUM_TAPS_BITS'(NUM_TAPS_RESET);
         decimation_ff <= DECIMATION_BITS'(DECIMATION_RESET);
      end else if (csr_fire) begin
         unique case (csr_if.index)
            CSR_NUM_TAPS: begin
               num_taps_ff <= csr_if.data[NUM_TAPS_BITS-1:0];
            end
            CSR_DECIMATION: begin
               decimation_ff <= csr_if.data[DECIMATION_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ rtl/dcf_checker.sv @@
// Port-level checker of the decimating complex FIR filter and its bind to the top level.
`default_nettype none
`include "decimating_complex_fir_filter_defines.svh"

module dcf_checker import dcf_pkg::*; (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic signed [OUT_BITS-1:0] rsp_out_re,
   input wire logic signed [OUT_BITS-1:0] rsp_out_im
);

   `DCF_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `DCF_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_out_re) && $stable(rsp_out_im))
   `DCF_ASSERT_IMPL(a_rsp_after_busy, clock, reset, $rose(rsp_valid), $past(!req_ready))
   `DCF_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_valid && req_ready, !$rose(rsp_valid))

endmodule

bind decimating_complex_fir_filter dcf_checker u_dcf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_out_re (rsp_if.out_re),
   .rsp_out_im (rsp_if.out_im)
);

`default_nettype wire
